### sv/mtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_pkg - shared types and constants of the massager tick controller
// Item layouts, configuration register map and reset values, and the small
// per-mode and per-level tables.
// ----------------------------------------------------------------------------
package mtc_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LONG_PRESS    = 3'd0,
        CFG_SHORT_PRESS   = 3'd1,
        CFG_TICKS_PER_SEC = 3'd2,
        CFG_AUTO_OFF      = 3'd3,
        CFG_SLEEP_IDLE    = 3'd4,
        CFG_BLINK         = 3'd5,
        CFG_REVERSAL_DEAD = 3'd6
    } cfg_index_t;

    // Register reset values
    localparam logic [7:0]  RST_LONG_PRESS    = 8'd100;
    localparam logic [7:0]  RST_SHORT_PRESS   = 8'd8;
    localparam logic [7:0]  RST_TICKS_PER_SEC = 8'd100;
    localparam logic [15:0] RST_AUTO_OFF      = 16'd900;
    localparam logic [7:0]  RST_SLEEP_IDLE    = 8'd200;
    localparam logic [7:0]  RST_BLINK         = 8'd50;
    localparam logic [7:0]  RST_REVERSAL_DEAD = 8'd50;

    // Key bit positions in the remembered key combination
    localparam int KEY_MODE_BIT = 0;
    localparam int KEY_UP_BIT   = 1;
    localparam int KEY_DOWN_BIT = 2;

    // Work modes and levels
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_FIRST = 3'd1;
    localparam logic [2:0] MODE_TWO   = 3'd2;
    localparam logic [2:0] MODE_THREE = 3'd3;
    localparam logic [2:0] MODE_LAST  = 3'd4;
    localparam logic [1:0] LEVEL_NONE = 2'd0;
    localparam logic [1:0] LEVEL_MIN  = 2'd1;
    localparam logic [1:0] LEVEL_MAX  = 2'd3;

    // Margin in ticks before each second's end in which the LED goes dark while powered off
    localparam logic [8:0] LED_OFF_MARGIN = 9'd4;

    typedef struct packed {
        logic [7:0]  long_press_ticks;
        logic [7:0]  short_press_ticks;
        logic [7:0]  ticks_per_second;
        logic [15:0] auto_off_seconds;
        logic [7:0]  sleep_idle_ticks;
        logic [7:0]  blink_ticks;
        logic [7:0]  reversal_dead_ticks;
    } cfg_t;

    typedef struct packed {
        logic key_mode;
        logic key_up;
        logic key_down;
        logic sensor_forward;
        logic sensor_reverse;
    } in_item_t;

    typedef struct packed {
        logic       solenoid_on;
        logic       vibrator_on;
        logic       tapper_on;
        logic [7:0] tapper_duty;
        logic [6:0] drive_duty;
        logic       forward_on;
        logic       reverse_on;
        logic       led_on;
        logic       sleep_request;
        logic       power_state;
        logic [2:0] mode_now;
        logic [1:0] level_now;
    } out_item_t;

    // Saturating 8-bit increment
    function automatic logic [7:0] sat8_inc(input logic [7:0] v);
        return (v == 8'hFF) ? 8'hFF : v + 8'd1;
    endfunction

    // Work phase length in seconds for a mode
    function automatic logic [7:0] work_reload_of(input logic [2:0] m);
        logic [7:0] r;
        case (m)
            MODE_FIRST: r = 8'd120;
            MODE_TWO:   r = 8'd80;
            MODE_THREE: r = 8'd40;
            default:    r = 8'd60;
        endcase
        return r;
    endfunction

    // Rest phase length in seconds for a mode
    function automatic logic [7:0] rest_reload_of(input logic [2:0] m);
        logic [7:0] r;
        case (m)
            MODE_FIRST: r = 8'd30;
            MODE_TWO:   r = 8'd10;
            MODE_THREE: r = 8'd10;
            default:    r = 8'd20;
        endcase
        return r;
    endfunction

    // Tapper duty, level times 60
    function automatic logic [7:0] tapper_duty_of(input logic [1:0] lv);
        logic [7:0] d;
        case (lv)
            2'd1:    d = 8'd60;
            2'd2:    d = 8'd120;
            2'd3:    d = 8'd180;
            default: d = 8'd0;
        endcase
        return d;
    endfunction

    // Drive duty, level times 30
    function automatic logic [6:0] drive_duty_of(input logic [1:0] lv);
        logic [6:0] d;
        case (lv)
            2'd1:    d = 7'd30;
            2'd2:    d = 7'd60;
            2'd3:    d = 7'd90;
            default: d = 7'd0;
        endcase
        return d;
    endfunction

endpackage

### sv/mtc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_in_if - tick input channel
// Valid/ready channel carrying one tick item: key and sensor levels.
// ----------------------------------------------------------------------------
interface mtc_in_if;
    logic valid;
    logic ready;
    logic key_mode;
    logic key_up;
    logic key_down;
    logic sensor_forward;
    logic sensor_reverse;

    modport source (
        output valid, key_mode, key_up, key_down, sensor_forward, sensor_reverse,
        input  ready
    );
    modport sink (
        input  valid, key_mode, key_up, key_down, sensor_forward, sensor_reverse,
        output ready
    );
endinterface

### sv/mtc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_out_if - result output channel
// Valid/ready channel carrying one result item: pin states, duties, status.
// ----------------------------------------------------------------------------
interface mtc_out_if;
    logic       valid;
    logic       ready;
    logic       solenoid_on;
    logic       vibrator_on;
    logic       tapper_on;
    logic [7:0] tapper_duty;
    logic [6:0] drive_duty;
    logic       forward_on;
    logic       reverse_on;
    logic       led_on;
    logic       sleep_request;
    logic       power_state;
    logic [2:0] mode_now;
    logic [1:0] level_now;

    modport source (
        output valid, solenoid_on, vibrator_on, tapper_on, tapper_duty, drive_duty,
               forward_on, reverse_on, led_on, sleep_request, power_state,
               mode_now, level_now,
        input  ready
    );
    modport sink (
        input  valid, solenoid_on, vibrator_on, tapper_on, tapper_duty, drive_duty,
               forward_on, reverse_on, led_on, sleep_request, power_state,
               mode_now, level_now,
        output ready
    );
endinterface

### sv/massager_tick_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// massager_tick_controller - tick controller for a three-key massager
// Key press classification, power and mode control, work/rest cycling,
// drive direction with dead time, LED blink and sleep request, one tick
// item in and one result item out.
// ----------------------------------------------------------------------------
// Each tick item gives exactly one result item. An item is held in the input
// register, then its tick is worked out in a single pass and lands in the
// result register, from which its result is presented as valid. One item is
// taken every cycle while the output side takes its results. A result waiting
// on the output still lets one more item into an empty input register; items
// after that wait until the result is taken. Configuration registers are
// written through the plain write port and act from the next tick; the user
// must write them only while no item is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
module massager_tick_controller
    import mtc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    mtc_in_if.sink                 in_ch,
    mtc_out_if.source              out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t      cfg;
    in_item_t  stage_item;
    logic      stage_valid;
    logic      step;
    out_item_t result;
    out_item_t out_reg;
    logic      out_valid_reg;
    logic      out_valid_next;

    mtc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mtc_input_stage u_input_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .advance    (step),
        .item_valid (stage_valid),
        .item       (stage_item)
    );

    // Tick runs when the result register is free or being emptied
    assign step = stage_valid && (!out_valid_reg || out_ch.ready);

    mtc_tick_core u_tick_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (stage_item),
        .cfg    (cfg),
        .result (result)
    );

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.solenoid_on   = out_reg.solenoid_on;
    assign out_ch.vibrator_on   = out_reg.vibrator_on;
    assign out_ch.tapper_on     = out_reg.tapper_on;
    assign out_ch.tapper_duty   = out_reg.tapper_duty;
    assign out_ch.drive_duty    = out_reg.drive_duty;
    assign out_ch.forward_on    = out_reg.forward_on;
    assign out_ch.reverse_on    = out_reg.reverse_on;
    assign out_ch.led_on        = out_reg.led_on;
    assign out_ch.sleep_request = out_reg.sleep_request;
    assign out_ch.power_state   = out_reg.power_state;
    assign out_ch.mode_now      = out_reg.mode_now;
    assign out_ch.level_now     = out_reg.level_now;

    // Sleep is only ever requested while powered off
    a_sleep_when_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.sleep_request |-> !out_reg.power_state)
        else $error("sleep request while powered");

    // Direction outputs are never driven together
    a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.forward_on && out_reg.reverse_on))
        else $error("forward and reverse both driven");

    // Powered means a live mode and level; off means none
    a_power_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.power_state == (out_reg.mode_now != MODE_NONE))
                          && (out_reg.power_state == (out_reg.level_now != LEVEL_NONE)))
        else $error("mode or level inconsistent with power state");

    // A held input item that could not run stays held
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid && !step |=> stage_valid)
        else $error("input item lost while stalled");

endmodule

### sv/mtc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_cfg_regs - configuration register file
// Seven write-only timing registers, loaded from the plain write port.
// ----------------------------------------------------------------------------
module mtc_cfg_regs
    import mtc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode; unused index is ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LONG_PRESS:    cfg_next.long_press_ticks    = cfg_data[7:0];
                CFG_SHORT_PRESS:   cfg_next.short_press_ticks   = cfg_data[7:0];
                CFG_TICKS_PER_SEC: cfg_next.ticks_per_second    = cfg_data[7:0];
                CFG_AUTO_OFF:      cfg_next.auto_off_seconds    = cfg_data;
                CFG_SLEEP_IDLE:    cfg_next.sleep_idle_ticks    = cfg_data[7:0];
                CFG_BLINK:         cfg_next.blink_ticks         = cfg_data[7:0];
                CFG_REVERSAL_DEAD: cfg_next.reversal_dead_ticks = cfg_data[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks    <= RST_LONG_PRESS;
            cfg_reg.short_press_ticks   <= RST_SHORT_PRESS;
            cfg_reg.ticks_per_second    <= RST_TICKS_PER_SEC;
            cfg_reg.auto_off_seconds    <= RST_AUTO_OFF;
            cfg_reg.sleep_idle_ticks    <= RST_SLEEP_IDLE;
            cfg_reg.blink_ticks         <= RST_BLINK;
            cfg_reg.reversal_dead_ticks <= RST_REVERSAL_DEAD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/mtc_input_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_input_stage - input register
// Captures one tick item; takes a new item while empty or whenever the held one moves on.
// ----------------------------------------------------------------------------
module mtc_input_stage
    import mtc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    mtc_in_if.sink  in_ch,
    input  logic    advance,
    output logic    item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    // Ready while empty or while the held item is leaving
    assign in_ch.ready = !valid_reg || advance;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.key_mode       <= in_ch.key_mode;
            item_reg.key_up         <= in_ch.key_up;
            item_reg.key_down       <= in_ch.key_down;
            item_reg.sensor_forward <= in_ch.sensor_forward;
            item_reg.sensor_reverse <= in_ch.sensor_reverse;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### sv/mtc_tick_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtc_tick_core - per-tick state update
// Holds the controller state and works out one tick in a single pass: key
// classification, second counter and auto-off, work/rest cycling, direction
// dead time, LED blink and sleep request.
// ----------------------------------------------------------------------------
module mtc_tick_core
    import mtc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    typedef enum logic [1:0] {
        PRESS_NONE  = 2'd0,
        PRESS_SHORT = 2'd1,
        PRESS_LONG  = 2'd2
    } press_kind_t;

    // State registers
    logic        powered_reg,        powered_next;
    logic        long_latched_reg,   long_latched_next;
    logic [2:0]  last_keys_reg,      last_keys_next;
    logic [7:0]  press_count_reg,    press_count_next;
    logic [2:0]  mode_reg,           mode_next;
    logic [1:0]  level_reg,          level_next;
    logic [7:0]  work_left_reg,      work_left_next;
    logic [7:0]  rest_left_reg,      rest_left_next;
    logic [7:0]  work_reload_reg,    work_reload_next;
    logic [7:0]  rest_reload_reg,    rest_reload_next;
    logic [7:0]  tick_in_sec_reg,    tick_in_sec_next;
    logic [15:0] off_countdown_reg,  off_countdown_next;
    logic [7:0]  blink_left_reg,     blink_left_next;
    logic [7:0]  idle_count_reg,     idle_count_next;
    logic        dir_forward_reg,    dir_forward_next;
    logic [7:0]  reversal_count_reg, reversal_count_next;
    logic        led_lit_reg,        led_lit_next;
    logic        pin_sol_reg,        pin_sol_next;
    logic        pin_vib_reg,        pin_vib_next;
    logic        pin_tap_reg,        pin_tap_next;
    logic        pin_fwd_reg,        pin_fwd_next;
    logic        pin_rev_reg,        pin_rev_next;

    logic        sleep_req;
    logic [2:0]  keys;
    press_kind_t press_kind;
    logic [8:0]  press_inc;
    logic [8:0]  tick_inc;

    assign keys = {item.key_down, item.key_up, item.key_mode};

    // One tick, worked out step by step in a single combinational pass
    always_comb
    begin
        powered_next        = powered_reg;
        long_latched_next   = long_latched_reg;
        last_keys_next      = last_keys_reg;
        press_count_next    = press_count_reg;
        mode_next           = mode_reg;
        level_next          = level_reg;
        work_left_next      = work_left_reg;
        rest_left_next      = rest_left_reg;
        work_reload_next    = work_reload_reg;
        rest_reload_next    = rest_reload_reg;
        off_countdown_next  = off_countdown_reg;
        blink_left_next     = blink_left_reg;
        idle_count_next     = idle_count_reg;
        dir_forward_next    = dir_forward_reg;
        reversal_count_next = reversal_count_reg;
        led_lit_next        = led_lit_reg;
        pin_sol_next        = pin_sol_reg;
        pin_vib_next        = pin_vib_reg;
        pin_tap_next        = pin_tap_reg;
        pin_fwd_next        = pin_fwd_reg;
        pin_rev_next        = pin_rev_reg;
        sleep_req           = 1'b0;
        press_kind          = PRESS_NONE;

        // Press classification; count saturates at the long press length
        press_inc = {1'b0, press_count_reg} + 9'd1;
        if (keys != 3'b000)
        begin
            last_keys_next = keys;
            if (press_inc >= {1'b0, cfg.long_press_ticks})
            begin
                press_count_next = cfg.long_press_ticks;
                if (!long_latched_reg)
                begin
                    long_latched_next = 1'b1;
                    press_kind        = PRESS_LONG;
                end
            end
            else
            begin
                press_count_next = press_inc[7:0];
            end
        end
        else
        begin
            press_count_next = 8'd0;
            if (press_count_reg >= cfg.long_press_ticks)
            begin
                long_latched_next = 1'b0;
            end
            else if (press_count_reg >= cfg.short_press_ticks)
            begin
                press_kind = PRESS_SHORT;
            end
        end

        // Key actions: mode key first, then up, then down
        case (press_kind)
            PRESS_SHORT:
            begin
                if (last_keys_next[KEY_MODE_BIT] && powered_reg)
                begin
                    blink_left_next  = cfg.blink_ticks;
                    mode_next        = (mode_reg >= MODE_LAST) ? MODE_FIRST : mode_reg + 3'd1;
                    work_reload_next = work_reload_of(mode_next);
                    rest_reload_next = rest_reload_of(mode_next);
                end
                else if (last_keys_next[KEY_UP_BIT] && powered_reg && mode_reg != MODE_NONE)
                begin
                    level_next = (level_reg < LEVEL_MAX) ? level_reg + 2'd1 : LEVEL_MAX;
                end
                else if (last_keys_next[KEY_DOWN_BIT] && powered_reg
                         && mode_reg != MODE_NONE)
                begin
                    level_next = (level_reg > LEVEL_MIN) ? level_reg - 2'd1 : LEVEL_MIN;
                end
            end
            PRESS_LONG:
            begin
                idle_count_next = 8'd0;
                if (last_keys_next[KEY_MODE_BIT])
                begin
                    powered_next = !powered_reg;
                end
                if (powered_next)
                begin
                    off_countdown_next = cfg.auto_off_seconds;
                    mode_next          = MODE_FIRST;
                    level_next         = LEVEL_MIN;
                    work_reload_next   = work_reload_of(MODE_FIRST);
                    rest_reload_next   = rest_reload_of(MODE_FIRST);
                end
            end
            default:
            begin
                press_kind = PRESS_NONE;
            end
        endcase

        // Second counter and auto-off countdown
        tick_inc = {1'b0, tick_in_sec_reg} + 9'd1;
        if (tick_inc >= {1'b0, cfg.ticks_per_second})
        begin
            tick_inc = 9'd0;
            if (off_countdown_next != 16'd0)
            begin
                off_countdown_next = off_countdown_next - 16'd1;
                if (off_countdown_next == 16'd0)
                begin
                    pin_sol_next = 1'b0;
                    pin_vib_next = 1'b0;
                    pin_tap_next = 1'b0;
                    pin_fwd_next = 1'b0;
                    pin_rev_next = 1'b0;
                    powered_next = 1'b0;
                    mode_next    = MODE_NONE;
                    level_next   = LEVEL_NONE;
                    led_lit_next = 1'b0;
                end
            end
        end
        tick_in_sec_next = tick_inc[7:0];

        if (powered_next)
        begin
            // Work/rest cycling, counted in seconds
            if (mode_next != MODE_NONE)
            begin
                if (work_left_next != 8'd0)
                begin
                    if (tick_in_sec_next == 8'd0)
                    begin
                        work_left_next = work_left_next - 8'd1;
                    end
                    rest_left_next = rest_reload_next;
                    pin_sol_next   = 1'b1;
                    pin_tap_next   = 1'b1;
                    pin_vib_next   = 1'b1;
                end
                else
                begin
                    pin_sol_next = 1'b0;
                    pin_tap_next = 1'b0;
                    pin_vib_next = 1'b0;
                    if (rest_left_next != 8'd0)
                    begin
                        if (tick_in_sec_next == 8'd0)
                        begin
                            rest_left_next = rest_left_next - 8'd1;
                        end
                        if (rest_left_next == 8'd0)
                        begin
                            work_left_next = work_reload_next;
                        end
                    end
                    else
                    begin
                        work_left_next = work_reload_next;
                    end
                end
            end

            // Direction with dead time; forward sensor wins
            reversal_count_next = sat8_inc(reversal_count_reg);
            if (item.sensor_forward)
            begin
                if (!dir_forward_reg)
                begin
                    reversal_count_next = 8'd0;
                end
                dir_forward_next = 1'b1;
            end
            else if (item.sensor_reverse)
            begin
                if (dir_forward_reg)
                begin
                    reversal_count_next = 8'd0;
                end
                dir_forward_next = 1'b0;
            end
            if (reversal_count_next < cfg.reversal_dead_ticks)
            begin
                pin_fwd_next = 1'b0;
                pin_rev_next = 1'b0;
            end
            if (reversal_count_next > cfg.reversal_dead_ticks)
            begin
                pin_fwd_next        = dir_forward_next;
                pin_rev_next        = !dir_forward_next;
                reversal_count_next = sat8_inc(cfg.reversal_dead_ticks);
            end

            // LED blink blanks the outputs
            if (blink_left_next != 8'd0)
            begin
                led_lit_next    = 1'b0;
                blink_left_next = blink_left_next - 8'd1;
                pin_sol_next    = 1'b0;
                pin_vib_next    = 1'b0;
                pin_tap_next    = 1'b0;
                pin_fwd_next    = 1'b0;
                pin_rev_next    = 1'b0;
            end
            else
            begin
                led_lit_next = 1'b1;
            end
        end
        else
        begin
            // Powered off: outputs dark, idle count towards sleep
            pin_sol_next = 1'b0;
            pin_vib_next = 1'b0;
            pin_tap_next = 1'b0;
            pin_fwd_next = 1'b0;
            pin_rev_next = 1'b0;
            mode_next    = MODE_NONE;
            level_next   = LEVEL_NONE;
            if ({1'b0, tick_in_sec_next} + LED_OFF_MARGIN >= {1'b0, cfg.ticks_per_second})
            begin
                led_lit_next = 1'b0;
            end
            idle_count_next = sat8_inc(idle_count_next);
            if (idle_count_next > cfg.sleep_idle_ticks)
            begin
                idle_count_next = 8'd0;
                sleep_req       = 1'b1;
            end
        end
    end

    // Result of this tick
    always_comb
    begin
        result.solenoid_on   = pin_sol_next;
        result.vibrator_on   = pin_vib_next;
        result.tapper_on     = pin_tap_next;
        result.tapper_duty   = tapper_duty_of(level_next);
        result.drive_duty    = drive_duty_of(level_next);
        result.forward_on    = pin_fwd_next;
        result.reverse_on    = pin_rev_next;
        result.led_on        = led_lit_next;
        result.sleep_request = sleep_req;
        result.power_state   = powered_next;
        result.mode_now      = mode_next;
        result.level_now     = level_next;
    end

    // State update once per tick item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            powered_reg        <= 1'b0;
            long_latched_reg   <= 1'b0;
            last_keys_reg      <= 3'd0;
            press_count_reg    <= 8'd0;
            mode_reg           <= MODE_NONE;
            level_reg          <= LEVEL_NONE;
            work_left_reg      <= 8'd0;
            rest_left_reg      <= 8'd0;
            work_reload_reg    <= 8'd0;
            rest_reload_reg    <= 8'd0;
            tick_in_sec_reg    <= 8'd0;
            off_countdown_reg  <= 16'd0;
            blink_left_reg     <= 8'd0;
            idle_count_reg     <= 8'd0;
            dir_forward_reg    <= 1'b0;
            reversal_count_reg <= 8'd0;
            led_lit_reg        <= 1'b1;
            pin_sol_reg        <= 1'b0;
            pin_vib_reg        <= 1'b0;
            pin_tap_reg        <= 1'b0;
            pin_fwd_reg        <= 1'b0;
            pin_rev_reg        <= 1'b0;
        end
        else if (step)
        begin
            powered_reg        <= powered_next;
            long_latched_reg   <= long_latched_next;
            last_keys_reg      <= last_keys_next;
            press_count_reg    <= press_count_next;
            mode_reg           <= mode_next;
            level_reg          <= level_next;
            work_left_reg      <= work_left_next;
            rest_left_reg      <= rest_left_next;
            work_reload_reg    <= work_reload_next;
            rest_reload_reg    <= rest_reload_next;
            tick_in_sec_reg    <= tick_in_sec_next;
            off_countdown_reg  <= off_countdown_next;
            blink_left_reg     <= blink_left_next;
            idle_count_reg     <= idle_count_next;
            dir_forward_reg    <= dir_forward_next;
            reversal_count_reg <= reversal_count_next;
            led_lit_reg        <= led_lit_next;
            pin_sol_reg        <= pin_sol_next;
            pin_vib_reg        <= pin_vib_next;
            pin_tap_reg        <= pin_tap_next;
            pin_fwd_reg        <= pin_fwd_next;
            pin_rev_reg        <= pin_rev_next;
        end
    end

endmodule
